>>> rtl/spr_pkg.sv
`default_nettype none

package spr_pkg;

  // Fixed field widths of the record and result
  localparam int COUNT_W     = 32;
  localparam int OWNER_W     = 3;
  localparam int SLOT_PAGE_W = 4;
  localparam int FREE_W      = 3;
  localparam int OUT_SLOTS   = 4;

  // Parameter defaults
  localparam int DEF_PHYSICAL_PAGES = 6;
  localparam int DEF_LOGICAL_SLOTS  = 4;

  typedef logic signed [COUNT_W-1:0]     count_t;
  typedef logic signed [SLOT_PAGE_W-1:0] slot_page_t;

  localparam count_t     COUNT_CEILING = 32'sh7FFF_FFFF;
  localparam count_t     COUNT_NONE    = -32'sd1;
  localparam slot_page_t NO_PAGE       = -4'sd1;

  // Top level sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DELIVER
  } spr_state_t;

  // Status from the free page search unit
  typedef struct packed {
    logic done;
    logic found;
  } spr_search_t;

endpackage

`default_nettype wire

>>> rtl/spr_free_search.sv
`default_nettype none

// Walks the physical pages one per cycle with a single signed compare,
// keeping the lowest counter among pages that no slot maps.
module spr_free_search #(
  parameter int PHYSICAL_PAGES = spr_pkg::DEF_PHYSICAL_PAGES,
  parameter int LOGICAL_SLOTS  = spr_pkg::DEF_LOGICAL_SLOTS,
  parameter int PAGE_W         = (PHYSICAL_PAGES > 1) ? $clog2(PHYSICAL_PAGES) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire spr_pkg::slot_page_t  slot_page [LOGICAL_SLOTS],
  input  wire spr_pkg::count_t      page_count,
  output logic [PAGE_W-1:0]         page_idx,
  output logic [PAGE_W-1:0]         best_page,
  output spr_pkg::spr_search_t      status
);
  import spr_pkg::*;

  localparam logic [PAGE_W-1:0] LAST_PAGE = PAGE_W'(PHYSICAL_PAGES - 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              found_r, found_nxt;
  logic [PAGE_W-1:0] idx_r, idx_nxt;
  logic [PAGE_W-1:0] page_r, page_nxt;
  count_t            best_r, best_nxt;
  logic              mapped;
  logic              take;

  // Is the page under test held by any slot
  always_comb begin
    mapped = 1'b0;
    for (int s = 0; s < LOGICAL_SLOTS; s++) begin
      if (slot_page[s] == SLOT_PAGE_W'(idx_r)) mapped = 1'b1;
    end
  end

  // Shared compare: strictly lower keeps ties on the lower page
  assign take = busy_r && !mapped && (page_count < best_r);

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    found_nxt = found_r;
    idx_nxt   = idx_r;
    page_nxt  = page_r;
    best_nxt  = best_r;
    if (start) begin
      busy_nxt  = 1'b1;
      found_nxt = 1'b0;
      idx_nxt   = '0;
      best_nxt  = COUNT_CEILING;
    end else if (busy_r) begin
      if (take) begin
        best_nxt  = page_count;
        page_nxt  = idx_r;
        found_nxt = 1'b1;
      end
      if (idx_r == LAST_PAGE) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      found_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      found_r <= found_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r <= page_nxt;
    best_r <= best_nxt;
  end

  assign page_idx     = idx_r;
  assign best_page    = page_r;
  assign status.done  = done_r;
  assign status.found = found_r;

endmodule

`default_nettype wire

>>> rtl/save_page_rotation_policy.sv
`default_nettype none

// Channel  Direction  Ports
// ------   ---------  -------------------------------------------------------
// in       request    in_valid/in_ready: record_valid, owner_slot,
//                     save_counter, final_page
// out      result     out_valid/out_ready: slot0..3_page, free_page,
//                     free_page_changed
//
// A non-final record leaves the block ready for the next record. A final record
// starts the search unit, which steps page by page through its shared 32-bit
// compare; the sequencer then takes its status and loads the result. A stalled
// output only holds the block after the next final record's search. Reset is
// synchronous, active low, and puts all tables at their cleared values.
module save_page_rotation_policy #(
  parameter int PHYSICAL_PAGES = spr_pkg::DEF_PHYSICAL_PAGES,
  parameter int LOGICAL_SLOTS  = spr_pkg::DEF_LOGICAL_SLOTS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            in_record_valid,
  input  wire logic [spr_pkg::OWNER_W-1:0]     in_owner_slot,
  input  wire logic signed [spr_pkg::COUNT_W-1:0] in_save_counter,
  input  wire logic                            in_final_page,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic signed [spr_pkg::SLOT_PAGE_W-1:0] out_slot0_page,
  output logic signed [spr_pkg::SLOT_PAGE_W-1:0] out_slot1_page,
  output logic signed [spr_pkg::SLOT_PAGE_W-1:0] out_slot2_page,
  output logic signed [spr_pkg::SLOT_PAGE_W-1:0] out_slot3_page,
  output logic [spr_pkg::FREE_W-1:0]           out_free_page,
  output logic                                 out_free_page_changed
);
  import spr_pkg::*;

  localparam int PAGE_W = (PHYSICAL_PAGES > 1) ? $clog2(PHYSICAL_PAGES) : 1;
  localparam int POS_W  = $clog2(PHYSICAL_PAGES + 1);
  localparam int SLOT_W = (LOGICAL_SLOTS > 1) ? $clog2(LOGICAL_SLOTS) : 1;
  localparam logic [POS_W-1:0]   POS_END   = POS_W'(PHYSICAL_PAGES);
  localparam logic [OWNER_W-1:0] OWNER_END = OWNER_W'(LOGICAL_SLOTS);

  spr_state_t  state_r, state_nxt;
  spr_search_t srch;

  slot_page_t  slot_page_r  [LOGICAL_SLOTS];
  slot_page_t  slot_page_nxt[LOGICAL_SLOTS];
  count_t      slot_cnt_r   [LOGICAL_SLOTS];
  count_t      slot_cnt_nxt [LOGICAL_SLOTS];
  count_t      page_cnt_r   [PHYSICAL_PAGES];
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [PAGE_W-1:0] free_r, free_nxt;
  logic [PAGE_W-1:0] search_idx;
  logic [PAGE_W-1:0] best_page;
  logic              changed_r, changed_nxt;

  logic              accept;
  logic              rec_ok;
  logic              in_range;
  logic [SLOT_W-1:0] owner_idx;
  logic              out_load;
  logic              out_valid_r;
  slot_page_t        slot_out[OUT_SLOTS];

  assign accept    = in_valid && in_ready;
  assign in_range  = (pos_r < POS_END);
  assign rec_ok    = in_record_valid && (in_owner_slot < OWNER_END) && in_range;
  assign owner_idx = in_owner_slot[SLOT_W-1:0];

  // Slot table update: clear at scan start, then newest counter wins
  always_comb begin
    for (int s = 0; s < LOGICAL_SLOTS; s++) begin
      slot_page_nxt[s] = (pos_r == '0) ? NO_PAGE : slot_page_r[s];
      slot_cnt_nxt[s]  = (pos_r == '0) ? COUNT_NONE : slot_cnt_r[s];
    end
    if (rec_ok && (slot_cnt_nxt[owner_idx] < in_save_counter)) begin
      slot_page_nxt[owner_idx] = SLOT_PAGE_W'(pos_r);
      slot_cnt_nxt[owner_idx]  = in_save_counter;
    end
  end

  // Page position: advance to the end of the table, restart after final
  always_comb begin
    pos_nxt = pos_r;
    if (in_final_page) pos_nxt = '0;
    else if (in_range) pos_nxt = pos_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      for (int s = 0; s < LOGICAL_SLOTS; s++) begin
        slot_page_r[s] <= NO_PAGE;
        slot_cnt_r[s]  <= COUNT_NONE;
      end
      for (int p = 0; p < PHYSICAL_PAGES; p++) page_cnt_r[p] <= '0;
    end else if (accept) begin
      pos_r <= pos_nxt;
      for (int s = 0; s < LOGICAL_SLOTS; s++) begin
        slot_page_r[s] <= slot_page_nxt[s];
        slot_cnt_r[s]  <= slot_cnt_nxt[s];
      end
      if (rec_ok) page_cnt_r[pos_r[PAGE_W-1:0]] <= in_save_counter;
    end
  end

  // Free page search over all pages
  spr_free_search #(
    .PHYSICAL_PAGES (PHYSICAL_PAGES),
    .LOGICAL_SLOTS  (LOGICAL_SLOTS),
    .PAGE_W         (PAGE_W)
  ) u_search (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (accept && in_final_page),
    .slot_page  (slot_page_r),
    .page_count (page_cnt_r[search_idx]),
    .page_idx   (search_idx),
    .best_page  (best_page),
    .status     (srch)
  );

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    free_nxt    = free_r;
    changed_nxt = changed_r;
    out_load    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_final_page) state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (srch.done) begin
          changed_nxt = srch.found;
          if (srch.found) free_nxt = best_page;
          state_nxt = ST_DELIVER;
        end
      end
      ST_DELIVER: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      free_r      <= '0;
      changed_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      free_r    <= free_nxt;
      changed_r <= changed_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Slots beyond the configured count read as no page
  generate
    for (genvar s = 0; s < OUT_SLOTS; s++) begin : g_slot_out
      if (s < LOGICAL_SLOTS) begin : g_live
        assign slot_out[s] = slot_page_r[s];
      end else begin : g_absent
        assign slot_out[s] = NO_PAGE;
      end
    end
  endgenerate

  // Output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_slot0_page        <= slot_out[0];
      out_slot1_page        <= slot_out[1];
      out_slot2_page        <= slot_out[2];
      out_slot3_page        <= slot_out[3];
      out_free_page         <= FREE_W'(free_r);
      out_free_page_changed <= changed_r;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

>>> test/spr_scan_checker.sv
module spr_scan_checker
  import spr_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  input  wire logic                       in_ready,
  input  wire logic                       in_record_valid,
  input  wire logic [OWNER_W-1:0]         in_owner_slot,
  input  wire logic signed [COUNT_W-1:0]  in_save_counter,
  input  wire logic                       in_final_page,
  input  wire logic                       out_valid,
  input  wire logic                       out_ready,
  input  wire logic signed [SLOT_PAGE_W-1:0] out_slot0_page,
  input  wire logic signed [SLOT_PAGE_W-1:0] out_slot1_page,
  input  wire logic signed [SLOT_PAGE_W-1:0] out_slot2_page,
  input  wire logic signed [SLOT_PAGE_W-1:0] out_slot3_page,
  input  wire logic [FREE_W-1:0]          out_free_page,
  input  wire logic                       out_free_page_changed,
  output int                              error_count,
  output int                              pending_count,
  output int                              checked_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAGES = DEF_PHYSICAL_PAGES;
  localparam int SLOTS = DEF_LOGICAL_SLOTS;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    slot_page_t [OUT_SLOTS-1:0] slot_pg;
    logic [FREE_W-1:0]          free_pg;
    logic                       changed;
  } scan_result_t;

  // Mirror of the mapping state
  slot_page_t        newest_page [SLOTS];
  count_t            newest_count [SLOTS];
  count_t            page_count [PAGES];
  logic [FREE_W-1:0] free_pg_q;
  int                scan_pos;
  scan_result_t      results_due [$];
  int                errors;
  int                checked;

  task automatic clear_slot_map();
    int s;
    for (s = 0; s < SLOTS; s++) begin
      newest_page[s]  = NO_PAGE;
      newest_count[s] = COUNT_NONE;
    end
  endtask

  // One page header: update tables, and on the last page search for the free page
  task automatic apply_page_record(input logic rec_valid, input logic [OWNER_W-1:0] owner,
                                   input count_t counter, input logic last);
    count_t       best;
    logic         mapped;
    scan_result_t res;
    int           p;
    int           s;
    if (scan_pos == 0) clear_slot_map();
    if (scan_pos < PAGES) begin
      // out-of-range owner is treated like a bad header
      if (rec_valid && owner < SLOTS) begin
        page_count[scan_pos] = counter;
        if (newest_count[owner] < counter) begin
          newest_page[owner]  = slot_page_t'(scan_pos);
          newest_count[owner] = counter;
        end
      end
      scan_pos++;
    end
    if (last) begin
      best = COUNT_CEILING;
      res.changed = 1'b0;
      for (p = 0; p < PAGES; p++) begin
        mapped = 1'b0;
        for (s = 0; s < SLOTS; s++)
          if (newest_page[s] == p) mapped = 1'b1;
        // strict compare keeps ties on the lower page
        if (!mapped && page_count[p] < best) begin
          best        = page_count[p];
          free_pg_q   = FREE_W'(p);
          res.changed = 1'b1;
        end
      end
      scan_pos = 0;
      for (s = 0; s < OUT_SLOTS; s++)
        res.slot_pg[s] = (s < SLOTS) ? newest_page[s] : NO_PAGE;
      res.free_pg = free_pg_q;
      results_due.push_back(res);
    end
  endtask

  always @(posedge clk) begin
    scan_result_t exp_res;
    scan_result_t got;
    int p;
    if (!rst_n) begin
      clear_slot_map();
      for (p = 0; p < PAGES; p++) page_count[p] = '0;
      free_pg_q = '0;
      scan_pos  = 0;
      results_due.delete();
      errors  = 0;
      checked = 0;
    end else begin
      // result side first: it can never belong to a request taken at this edge
      if (out_valid && out_ready) begin
        got.slot_pg[0] = out_slot0_page;
        got.slot_pg[1] = out_slot1_page;
        got.slot_pg[2] = out_slot2_page;
        got.slot_pg[3] = out_slot3_page;
        got.free_pg    = out_free_page;
        got.changed    = out_free_page_changed;
        if (results_due.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected result slots %0d %0d %0d %0d free %0d changed %0d",
                     $realtime, got.slot_pg[0], got.slot_pg[1], got.slot_pg[2],
                     got.slot_pg[3], got.free_pg, got.changed);
        end else begin
          exp_res = results_due.pop_front();
          checked++;
          if (got.slot_pg[0] !== exp_res.slot_pg[0] || got.slot_pg[1] !== exp_res.slot_pg[1] ||
              got.slot_pg[2] !== exp_res.slot_pg[2] || got.slot_pg[3] !== exp_res.slot_pg[3] ||
              got.free_pg !== exp_res.free_pg || got.changed !== exp_res.changed) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
              $display("%0t: mismatch expected slots %0d %0d %0d %0d free %0d changed %0d",
                       $realtime, exp_res.slot_pg[0], exp_res.slot_pg[1], exp_res.slot_pg[2],
                       exp_res.slot_pg[3], exp_res.free_pg, exp_res.changed);
              $display("%0t:          actual   slots %0d %0d %0d %0d free %0d changed %0d",
                       $realtime, got.slot_pg[0], got.slot_pg[1], got.slot_pg[2],
                       got.slot_pg[3], got.free_pg, got.changed);
            end
          end
        end
      end
      if (in_valid && in_ready)
        apply_page_record(in_record_valid, in_owner_slot, in_save_counter, in_final_page);
    end
    error_count   <= errors;
    pending_count <= results_due.size();
    checked_count <= checked;
  end

endmodule

>>> test/tb_save_page_rotation_policy.sv
module tb_save_page_rotation_policy;
  timeunit 1ns;
  timeprecision 1ps;
  import spr_pkg::*;

  localparam int RECORD_TARGET = 1500;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic              in_record_valid;
  logic [OWNER_W-1:0] in_owner_slot;
  count_t            in_save_counter;
  logic              in_final_page;
  logic              out_valid;
  logic              out_ready;
  slot_page_t        out_slot0_page;
  slot_page_t        out_slot1_page;
  slot_page_t        out_slot2_page;
  slot_page_t        out_slot3_page;
  logic [FREE_W-1:0] out_free_page;
  logic              out_free_page_changed;

  int   fail_count;
  int   results_open;
  int   results_checked;
  int   records_sent;
  int   scans_sent;
  logic steady_flow;

  save_page_rotation_policy u_top (.*);

  spr_scan_checker u_check (
    .clk, .rst_n, .in_valid, .in_ready, .in_record_valid, .in_owner_slot,
    .in_save_counter, .in_final_page, .out_valid, .out_ready, .out_slot0_page,
    .out_slot1_page, .out_slot2_page, .out_slot3_page, .out_free_page,
    .out_free_page_changed,
    .error_count(fail_count), .pending_count(results_open),
    .checked_count(results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #15_000_000;
    $display("Verification failed");
    $finish;
  end

  // Mostly short idle stretches, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Counters biased toward small values for ties, plus the extremes
  function automatic count_t pick_counter();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return count_t'($urandom);
    if (r == 2) return COUNT_CEILING;
    if (r == 3) return count_t'(32'h8000_0000);
    if (r == 4) return COUNT_CEILING - count_t'($urandom_range(1, 2));
    return count_t'($urandom_range(0, 20)) - 32'sd4;
  endfunction

  // Result side back-pressure
  initial begin
    int hold;
    out_ready = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
      end else if (out_ready) begin
        hold = idle_len();
        if (hold > 0) out_ready <= 1'b0;
        else hold = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                 : $urandom_range(0, 8);
      end else begin
        out_ready <= 1'b1;
        hold = $urandom_range(0, 8);
      end
    end
  end

  // One request; valid stays up across back-to-back requests
  task automatic send_record(input logic rec_valid, input logic [OWNER_W-1:0] owner,
                             input count_t counter, input logic last);
    int gap;
    gap = steady_flow ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_record_valid <= rec_valid;
    in_owner_slot   <= owner;
    in_save_counter <= counter;
    in_final_page   <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    records_sent++;
    if (last) scans_sent++;
  endtask

  // A scan of random headers, final flag on its last record
  task automatic send_random_scan(input int n_records);
    int i;
    logic [OWNER_W-1:0] owner;
    steady_flow = ($urandom_range(0, 3) == 0);
    for (i = 0; i < n_records; i++) begin
      owner = ($urandom_range(0, 99) < 85) ? OWNER_W'($urandom_range(0, 3))
                                            : OWNER_W'($urandom_range(4, 7));
      send_record($urandom_range(0, 9) != 0, owner, pick_counter(), i == n_records - 1);
    end
  endtask

  initial begin
    int r;
    int i;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_record_valid = 1'b0;
    in_owner_slot   = '0;
    in_save_counter = '0;
    in_final_page   = 1'b0;
    steady_flow     = 1'b0;
    records_sent    = 0;
    scans_sent      = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Full scan: extremes, a bad header, an out-of-range owner, a slot moving pages
    send_record(1'b1, 3'd0, 32'sd5, 1'b0);
    send_record(1'b1, 3'd1, COUNT_CEILING, 1'b0);
    send_record(1'b0, 3'd2, count_t'(32'h8000_0000), 1'b0);
    send_record(1'b1, 3'd7, 32'sd0, 1'b0);
    send_record(1'b1, 3'd0, 32'sd10, 1'b0);
    send_record(1'b1, 3'd3, count_t'(32'h8000_0000), 1'b1);
    // Short scan: unseen pages keep their old entries
    send_record(1'b1, 3'd2, 32'sd3, 1'b0);
    send_record(1'b1, 3'd4, 32'sd1, 1'b1);
    // Overlong scan: records past the last page are dropped
    for (i = 0; i < 8; i++)
      send_record(1'b1, OWNER_W'(i % 4), 32'sd100 + i, i == 7);
    // Every unmapped page at the ceiling: free page stays put
    for (i = 0; i < 6; i++)
      send_record(1'b1, 3'd0, COUNT_CEILING, i == 5);
    // Single-record scan
    send_record(1'b1, 3'd1, -32'sd1, 1'b1);

    // Random scans, mostly well formed
    while (records_sent < RECORD_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 70) send_random_scan(6);
      else if (r < 85) send_random_scan($urandom_range(1, 5));
      else send_random_scan($urandom_range(7, 10));
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (results_open != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d page headers in %0d scans; %0d scan results checked.",
             records_sent, scans_sent, results_checked);
    if (fail_count == 0 && results_open == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
